/* rtl/core/fbm_pkg.sv */
package fbm_pkg;

	localparam int OCTAVES_DEF = 6;
	localparam int COORD_W     = 32;
	localparam int HEIGHT_W    = 24;
	localparam int FRAC_W      = 16;
	localparam int OFS_W       = 18;   // f or f - 1.0, signed Q.16
	localparam int GRAD_W      = 19;   // sum of two offsets
	localparam int NOISE_W     = 20;   // lerp values and octave noise
	localparam int FADE_W      = 17;   // fade weight, Q0.16 with headroom
	localparam int LANE_LAT    = 5;
	localparam int NORM_LAT    = 3;

	// Only the low three hash bits pick a gradient, so the 32-bit hash
	// reduces to its low byte: the shifted terms drop out and every
	// constant reduces modulo 256.
	localparam logic [7:0] HASH_MUL = 8'h73;   // 15731 mod 256
	localparam logic [7:0] HASH_ADD = 8'hE5;   // 789221 mod 256
	localparam logic [7:0] HASH_MIX = 8'h0D;   // 1376312589 mod 256

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -24'sh800000;

	function automatic logic [2:0] grad_sel(logic [7:0] cx, logic [7:0] cy);
		logic [7:0] prd;
		logic [7:0] sum;
		prd = 8'(cx * cy);
		prd = 8'(prd * HASH_MUL) + HASH_ADD;
		sum = cx + 8'(cy * HASH_MIX);
		return 3'(prd ^ sum);
	endfunction

	function automatic logic signed [GRAD_W-1:0] gradient(logic [2:0] g,
		logic signed [OFS_W-1:0] dx, logic signed [OFS_W-1:0] dy);
		logic signed [GRAD_W-1:0] u;
		logic signed [GRAD_W-1:0] v;
		u = (g < 3'd4) ? GRAD_W'(dx) : GRAD_W'(dy);
		v = (g < 3'd2) ? GRAD_W'(dy) : GRAD_W'(dx);
		if (g[0])
			u = -u;
		if (g[1])
			v = -v;
		return u + v;
	endfunction

	// a + floor(t * (b - a) / 2^16)
	function automatic logic signed [NOISE_W-1:0] mix(logic signed [NOISE_W-1:0] a,
		logic signed [NOISE_W-1:0] b, logic [FADE_W-1:0] t);
		logic signed [NOISE_W:0] d;
		logic signed [NOISE_W+FADE_W+1:0] p;
		d = (NOISE_W+1)'(b) - (NOISE_W+1)'(a);
		p = d * $signed({1'b0, t});
		return a + NOISE_W'(p >>> FRAC_W);
	endfunction

endpackage

/* rtl/core/fbm_octave.sv */
module fbm_octave #(
	parameter int IDX = 0
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [fbm_pkg::COORD_W-1:0]        x_coord,
	input  logic signed [fbm_pkg::COORD_W-1:0]        z_coord,
	output logic signed [fbm_pkg::NOISE_W-1:0]        noise
);

	localparam int FW = fbm_pkg::FRAC_W;
	localparam int NW = fbm_pkg::NOISE_W;

	logic [63:0] xv, zv;
	logic [FW-1:0] fx, fy;
	logic [7:0] cx, cy, cx1, cy1;

	// scale by 2^IDX in units of 2^-17: cell above bit 17, fraction below
	assign xv  = 64'(x_coord) << IDX;
	assign zv  = 64'(z_coord) << IDX;
	assign fx  = xv[16:1];
	assign fy  = zv[16:1];
	assign cx  = xv[24:17];
	assign cy  = zv[24:17];
	assign cx1 = cx + 8'd1;
	assign cy1 = cy + 8'd1;

	// stage 1: hashes, squares
	logic [FW-1:0] fx_s1, fy_s1;
	logic [2*FW-1:0] fx2_s1, fy2_s1;
	logic [2:0] h00_s1, h10_s1, h01_s1, h11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1  <= fx;
			fy_s1  <= fy;
			fx2_s1 <= fx * fx;
			fy2_s1 <= fy * fy;
			h00_s1 <= fbm_pkg::grad_sel(cx, cy);
			h10_s1 <= fbm_pkg::grad_sel(cx1, cy);
			h01_s1 <= fbm_pkg::grad_sel(cx, cy1);
			h11_s1 <= fbm_pkg::grad_sel(cx1, cy1);
		end
	end

	// stage 2: cube, fade polynomial, corner gradients
	logic signed [fbm_pkg::OFS_W-1:0] dx0, dx1, dy0, dy1;
	logic [3*FW-1:0] fx3, fy3;
	logic [37:0] px, py;

	assign dx0 = {2'b00, fx_s1};
	assign dx1 = {2'b11, fx_s1};
	assign dy0 = {2'b00, fy_s1};
	assign dy1 = {2'b11, fy_s1};
	assign fx3 = fx2_s1 * fx_s1;
	assign fy3 = fy2_s1 * fy_s1;
	assign px  = 38'(fx2_s1) * 38'd6 - (38'(fx_s1) * 38'd15 << 16) + (38'd10 << 32);
	assign py  = 38'(fy2_s1) * 38'd6 - (38'(fy_s1) * 38'd15 << 16) + (38'd10 << 32);

	logic [FW-1:0] tx_s2, ty_s2;
	logic [19:0] px_s2, py_s2;
	logic signed [fbm_pkg::GRAD_W-1:0] n00_s2, n10_s2, n01_s2, n11_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2  <= fx3[3*FW-1:2*FW];
			ty_s2  <= fy3[3*FW-1:2*FW];
			px_s2  <= px[35:16];
			py_s2  <= py[35:16];
			n00_s2 <= fbm_pkg::gradient(h00_s1, dx0, dy0);
			n10_s2 <= fbm_pkg::gradient(h10_s1, dx1, dy0);
			n01_s2 <= fbm_pkg::gradient(h01_s1, dx0, dy1);
			n11_s2 <= fbm_pkg::gradient(h11_s1, dx1, dy1);
		end
	end

	// stage 3: fade weights
	logic [35:0] ux, uy;
	assign ux = tx_s2 * px_s2;
	assign uy = ty_s2 * py_s2;

	logic [fbm_pkg::FADE_W-1:0] ux_s3, uy_s3;
	logic signed [NW-1:0] n00_s3, n10_s3, n01_s3, n11_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s3  <= ux[32:16];
			uy_s3  <= uy[32:16];
			n00_s3 <= NW'(n00_s2);
			n10_s3 <= NW'(n10_s2);
			n01_s3 <= NW'(n01_s2);
			n11_s3 <= NW'(n11_s2);
		end
	end

	// stage 4: lerp along x
	logic signed [NW-1:0] r0_s4, r1_s4;
	logic [fbm_pkg::FADE_W-1:0] uy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s4 <= fbm_pkg::mix(n00_s3, n10_s3, ux_s3);
			r1_s4 <= fbm_pkg::mix(n01_s3, n11_s3, ux_s3);
			uy_s4 <= uy_s3;
		end
	end

	// stage 5: lerp along z
	logic signed [NW-1:0] noise_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			noise_s5 <= fbm_pkg::mix(r0_s4, r1_s4, uy_s4);
		end
	end

	assign noise = noise_s5;

endmodule

/* rtl/core/fbm_norm.sv */
module fbm_norm #(
	parameter int OCTAVES = fbm_pkg::OCTAVES_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [fbm_pkg::NOISE_W-1:0]   noise [OCTAVES],
	output logic signed [fbm_pkg::HEIGHT_W-1:0]  height
);

	localparam int ACC_W = fbm_pkg::NOISE_W + OCTAVES;
	localparam int MW    = ACC_W + 4;
	localparam longint unsigned DIV = (64'd1 << OCTAVES) - 64'd1;
	localparam logic [MW:0] REC = (MW+1)'((64'd1 << MW) / DIV);

	// stage 6: weighted sum, times 15, magnitude
	logic signed [ACC_W-1:0] acc;
	logic signed [MW-1:0] a15;

	always_comb begin
		acc = '0;
		for (int i = 0; i < OCTAVES; i++)
			acc = acc + (ACC_W'(noise[i]) <<< (OCTAVES - 1 - i));
		a15 = (MW'(acc) <<< 4) - MW'(acc);
	end

	logic neg_s6, neg_s7;
	logic [MW-1:0] mag_s6, mag_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= a15[MW-1];
			mag_s6 <= a15[MW-1] ? MW'(-a15) : MW'(a15);
		end
	end

	// stage 7: quotient estimate by reciprocal, low by at most one
	logic [2*MW:0] prod;
	logic [MW-1:0] q0_s7;
	assign prod = mag_s6 * REC;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s7 <= neg_s6;
			mag_s7 <= mag_s6;
			q0_s7  <= prod[2*MW-1:MW];
		end
	end

	// stage 8: correct, restore sign, saturate
	logic [MW+OCTAVES:0] qd, rem;
	logic [MW-1:0] q;
	logic signed [MW:0] qs;
	logic signed [fbm_pkg::HEIGHT_W-1:0] height_s8;

	always_comb begin
		qd  = ((MW+OCTAVES+1)'(q0_s7) << OCTAVES) - (MW+OCTAVES+1)'(q0_s7);
		rem = (MW+OCTAVES+1)'(mag_s7) - qd;
		q   = (rem >= (MW+OCTAVES+1)'(DIV)) ? q0_s7 + MW'(1) : q0_s7;
		qs  = neg_s7 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (qs > (MW+1)'(fbm_pkg::HEIGHT_MAX))
				height_s8 <= fbm_pkg::HEIGHT_MAX;
			else if (qs < (MW+1)'(fbm_pkg::HEIGHT_MIN))
				height_s8 <= fbm_pkg::HEIGHT_MIN;
			else
				height_s8 <= fbm_pkg::HEIGHT_W'(qs);
		end
	end

	assign height = height_s8;

endmodule

/* rtl/core/fbm_perlin_noise_2d_core.sv */
// Fractal terrain height from 2D Perlin gradient noise. Each word carries a
// point (x_coord, z_coord) in signed Q16.16 and returns one height in signed
// Q7.16: OCTAVES octaves of gradient noise at frequencies 0.5, 1, 2, ...
// with amplitudes halving from 1, normalized by the amplitude total, scaled
// by 15 and saturated. Each height passes 5 stages per octave lane for hash,
// fade and two lerps, then 3 stages to sum, divide and saturate.
// All octaves run as parallel lanes, so the rate is one word per cycle with
// no dependence between words, unless out_stall holds a finished word at
// the output. That stall freezes the whole pipeline; in_stall then follows
// out_stall in the same cycle.
module fbm_perlin_noise_2d_core #(
	parameter int OCTAVES = fbm_pkg::OCTAVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fbm_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [fbm_pkg::COORD_W-1:0]  z_coord,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fbm_pkg::HEIGHT_W-1:0] height
);

	localparam int LAT = fbm_pkg::LANE_LAT + fbm_pkg::NORM_LAT;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [fbm_pkg::NOISE_W-1:0] noise [OCTAVES];

	// advance everything unless a finished word waits at the output
	assign en       = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// one lane per octave, frequency 2^(i-1)
	for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
		fbm_octave #(
			.IDX(i)
		) u_oct (
			.clk     (clk),
			.en      (en),
			.x_coord (x_coord),
			.z_coord (z_coord),
			.noise   (noise[i])
		);
	end

	fbm_norm #(
		.OCTAVES(OCTAVES)
	) u_norm (
		.clk    (clk),
		.en     (en),
		.noise  (noise),
		.height (height)
	);

	assign out_valid = vld_q[LAT-1];

endmodule

/* rtl/core/fbm_checker.sv */
module fbm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [fbm_pkg::HEIGHT_W-1:0] height
);

	// a waiting word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(height))
		else $error("output word changed while stalled");

	// a full, stalled output pushes back on the input
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	// no output word waiting means the input is never stalled
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// the input stalls only when the output does
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("input stalled without output stall");

endmodule

bind fbm_perlin_noise_2d_core fbm_checker u_fbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.height    (height)
);

/* dv/fbm_perlin_noise_2d_core_tb.sv */
module fbm_perlin_noise_2d_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OCT       = fbm_pkg::OCTAVES_DEF;
	localparam int N_RANDOM  = 400;
	localparam int DRAIN_CYC = fbm_pkg::LANE_LAT + fbm_pkg::NORM_LAT + 8;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [fbm_pkg::COORD_W-1:0]  x_coord;
	logic signed [fbm_pkg::COORD_W-1:0]  z_coord;
	logic                                out_valid;
	logic                                out_stall;
	logic signed [fbm_pkg::HEIGHT_W-1:0] height;

	fbm_perlin_noise_2d_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_coord   (x_coord),
		.z_coord   (z_coord),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.height    (height)
	);

	always #5 clk = ~clk;

	// Directed point list. has_height marks rows whose height is typed in;
	// every other row is checked against the predictor.
	typedef struct {
		logic [31:0]  x;
		logic [31:0]  z;
		bit           has_height;
		logic [23:0]  h;
	} point_row_t;

	localparam int N_DIRECTED = 16;
	point_row_t points [N_DIRECTED];

	logic [23:0] height_q[$];   // heights still owed by the block
	int          n_err;
	int          n_heights;
	int          n_words;
	bit          quiet_tail;    // no idling in the last part of the run
	bit          sender_done;

	// Low byte of the corner hash; every term is kept at 32 bits and wraps.
	function automatic logic [7:0] corner_byte(logic [31:0] cx, logic [31:0] cy);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		a = (cx << 13) ^ cx;
		b = (cy << 17) ^ cy;
		r = (a * b * 32'd15731 + 32'd789221) ^ (a + b * 32'd1376312589);
		return r[7:0];
	endfunction

	function automatic longint grad_dot(logic [7:0] hsh, longint dx, longint dy);
		logic [2:0] g;
		longint     u;
		longint     v;
		g = hsh[2:0];
		u = (g < 3'd4) ? dx : dy;
		v = (g < 3'd2) ? dy : dx;
		return (g[0] ? -u : u) + (g[1] ? -v : v);
	endfunction

	function automatic longint quintic(longint f);
		logic [63:0] t3;
		logic [63:0] p;
		logic [63:0] fu;
		fu = f;
		t3 = (fu * fu * fu) >> 32;
		p  = (64'd6 * fu * fu - 64'd15 * 64'd65536 * fu + 64'd10 * (64'd1 << 32)) >> 16;
		return longint'((t3 * p) >> 16);
	endfunction

	// a + floor(t * (b - a) / 2^16); >>> on a signed longint floors.
	function automatic longint blend(longint a, longint b, longint t);
		return a + ((t * (b - a)) >>> fbm_pkg::FRAC_W);
	endfunction

	function automatic longint octave_val(longint x, longint z, int i);
		logic [63:0] sx;
		logic [63:0] sz;
		logic [31:0] cx;
		logic [31:0] cy;
		longint      fx;
		longint      fy;
		longint      ux;
		longint      uy;
		longint      n00, n10, n01, n11;
		sx = x * (64'sd1 <<< i);
		sz = z * (64'sd1 <<< i);
		cx = sx[48:17];
		cy = sz[48:17];
		fx = sx[16:1];
		fy = sz[16:1];
		ux = quintic(fx);
		uy = quintic(fy);
		n00 = grad_dot(corner_byte(cx, cy), fx, fy);
		n10 = grad_dot(corner_byte(cx + 1, cy), fx - 65536, fy);
		n01 = grad_dot(corner_byte(cx, cy + 1), fx, fy - 65536);
		n11 = grad_dot(corner_byte(cx + 1, cy + 1), fx - 65536, fy - 65536);
		return blend(blend(n00, n10, ux), blend(n01, n11, ux), uy);
	endfunction

	function automatic logic [23:0] terrain_height(logic [31:0] xr, logic [31:0] zr);
		longint x;
		longint z;
		longint acc;
		longint q;
		x   = longint'($signed(xr));
		z   = longint'($signed(zr));
		acc = 0;
		for (int i = 0; i < OCT; i++)
			acc += octave_val(x, z, i) * (64'sd1 <<< (OCT - 1 - i));
		q = (acc * 15) / ((64'sd1 <<< OCT) - 1);   // truncates toward zero
		if (q > 8388607)
			q = 8388607;
		if (q < -8388608)
			q = -8388608;
		return q[23:0];
	endfunction

	// Offer one word and hold it until accepted, sometimes after a random gap.
	task automatic send_point(logic [31:0] xr, logic [31:0] zr, bit typed, logic [23:0] h);
		int gap;
		bit held;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord  <= xr;
		z_coord  <= zr;
		// sample the stall between edges so it reflects the coming edge
		forever begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
			if (!held)
				break;
		end
		// word accepted at this edge
		height_q.push_back(typed ? h : terrain_height(xr, zr));
		n_words++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();                                   // anywhere, huge cells
			1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000; // near origin
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			3: return {16'($urandom()), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			default: return $urandom() & 32'h00FF_FFFF;
		endcase
	endfunction

	// Stimulus.
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		x_coord     = '0;
		z_coord     = '0;
		n_err       = 0;
		n_heights   = 0;
		n_words     = 0;
		quiet_tail  = 1'b0;
		sender_done = 1'b0;

		// Origin: every octave lands on a lattice corner, so the height is zero.
		points[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1, 24'h000000};
		points[1]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 'x};
		points[2]  = '{32'h8000_0000, 32'h8000_0000, 1'b0, 'x};
		points[3]  = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 'x};
		points[4]  = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 'x};
		points[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 'x};
		points[6]  = '{32'h0000_0001, 32'h0000_0001, 1'b0, 'x};
		points[7]  = '{32'h0000_8000, 32'h0000_8000, 1'b0, 'x};
		points[8]  = '{32'h0000_FFFF, 32'h0001_0000, 1'b0, 'x};
		points[9]  = '{32'hFFFF_0000, 32'h0000_C000, 1'b0, 'x};
		points[10] = '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 'x};
		points[11] = '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 'x};
		points[12] = '{32'h0002_0000, 32'h0000_0000, 1'b1, 24'h000000};
		points[13] = '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 'x};
		points[14] = '{32'h0000_7FFF, 32'hFFFF_8001, 1'b0, 'x};
		points[15] = '{32'h4000_0000, 32'hC000_0000, 1'b0, 'x};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (points[k])
			send_point(points[k].x, points[k].z, points[k].has_height, points[k].h);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				// hold the sender until the pipeline has drained completely
				in_valid <= 1'b0;
				@(posedge clk);
				while (height_q.size() != 0)
					@(posedge clk);
			end
			if (n == N_RANDOM - 60)
				quiet_tail = 1'b1;
			send_point(rand_coord(), rand_coord(), 1'b0, 'x);
		end
		in_valid    <= 1'b0;
		sender_done = 1'b1;
	end

	// Receiver: random stall bursts, none during the quiet tail.
	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Compare each accepted height with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (height_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("ERROR: height %0d with nothing expected", height);
			end else begin
				logic [23:0] want;
				want = height_q.pop_front();
				n_heights++;
				if (height !== want) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: height mismatch, expected %0d got %0d",
							$signed(want), height);
				end
			end
		end
	end

	// Finish once drained.
	initial begin
		@(posedge arst_n);
		wait (sender_done);
		while (height_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("Covered %0d points (directed extremes, wrapping cells, random), %0d heights checked.",
			n_words, n_heights);
		if (n_err == 0 && height_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Timeout guard.
	initial begin
		#2ms;
		$display("Timeout with %0d heights outstanding", height_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
